// ===== rtl/core/ndd_pkg.sv =====
// Shared types and constants for the Newton divided-difference interpolator.
// Used by ndd_ctrl, ndd_datapath, the top level and the checker.
`default_nettype none

package ndd_pkg;

  // Input opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_NONE = 3'd1;
  localparam logic [2:0] ST_DUP  = 3'd2;
  localparam logic [2:0] ST_SAT  = 3'd3;
  localparam logic [2:0] ST_DROP = 3'd4;

  // Restoring divider: 33-bit magnitude shifted left by 16 gives 49 quotient bits
  localparam int DIV_STEPS = 49;
  localparam int DIV_KW    = 6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ld_node;     // write x/y stores from the input ports
    logic w_wr_y;      // copy registered y read into the work store
    logic w_wr_q;      // write saturated quotient into the work store
    logic cap_eval;    // hold the evaluation abscissa
    logic cap_a;       // hold first operand pair (w[i], x[i])
    logic div_init;    // load divider from difference operands
    logic div_step;    // one restoring divide step
    logic p_load;      // load Horner accumulator from work read
    logic mul;         // form |p|*|x - x_i|
    logic horner_add;  // scale, add coefficient, saturate
    logic out_load;    // load result register
    logic out_zero;    // result value forced to zero
  } ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic den_zero;    // duplicate node abscissa
    logic q_sat;       // quotient saturated
    logic h_sat;       // Horner step saturated
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ndd_datapath.sv =====
// Datapath: node and work stores, divided-difference divider and Horner unit.
// Driven by ndd_ctrl through ndd_pkg::ctrl_t; depends on ndd_pkg.
`default_nettype none

module ndd_datapath #(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                          clk,
  input  wire logic [31:0]                   in_x_value,
  input  wire logic [31:0]                   in_y_value,
  input  wire ndd_pkg::ctrl_t                ctrl,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  wire logic [$clog2(MAX_POINTS)-1:0] x_addr,
  input  wire logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  output ndd_pkg::stat_t                     stat,
  output logic [31:0]                        out_poly_value
);

  // Stores
  logic [31:0] x_mem [MAX_POINTS];
  logic [31:0] y_mem [MAX_POINTS];
  logic [31:0] w_mem [MAX_POINTS];
  logic [31:0] x_q, y_q, w_q;

  // Operand, divider and Horner registers
  logic [31:0] xev_r, ax_r, aw_r;
  logic [48:0] dvd_r;
  logic [33:0] rem_r;
  logic [32:0] dvs_r;
  logic        qneg_r;
  logic [31:0] p_r, c_r;
  logic [63:0] prod_r;
  logic        pneg_r;
  logic [31:0] out_poly_r;

  logic [32:0] num, den, num_mag, den_mag, d, d_mag;
  logic [31:0] p_mag, qval;
  logic [33:0] trial;
  logic [49:0] tv, sv, sum;
  logic [31:0] hval;
  logic        q_pos_ovf, q_neg_ovf, h_ovf;

  // Write and read the stores
  always_ff @(posedge clk) begin
    if (ctrl.ld_node) begin
      x_mem[wr_addr] <= in_x_value;
      y_mem[wr_addr] <= in_y_value;
    end
    if (ctrl.w_wr_y) begin
      w_mem[wr_addr] <= y_q;
    end else if (ctrl.w_wr_q) begin
      w_mem[wr_addr] <= qval;
    end
    x_q <= x_mem[x_addr];
    y_q <= y_mem[rd_addr];
    w_q <= w_mem[rd_addr];
  end

  // Difference operands and divider step
  always_comb begin
    num     = {aw_r[31], aw_r} - {w_q[31], w_q};
    den     = {ax_r[31], ax_r} - {x_q[31], x_q};
    num_mag = num[32] ? (33'd0 - num) : num;
    den_mag = den[32] ? (33'd0 - den) : den;
    trial   = {rem_r[32:0], dvd_r[48]} - {1'b0, dvs_r};
  end

  // Saturate the signed quotient
  always_comb begin
    q_pos_ovf = |dvd_r[48:31];
    q_neg_ovf = (|dvd_r[48:32]) || (dvd_r[31] && (|dvd_r[30:0]));
    if (!qneg_r) begin
      qval = q_pos_ovf ? 32'h7fff_ffff : dvd_r[31:0];
    end else begin
      qval = q_neg_ovf ? 32'h8000_0000 : (32'd0 - dvd_r[31:0]);
    end
  end

  // Horner operands, scaling and saturation
  always_comb begin
    d     = {xev_r[31], xev_r} - {x_q[31], x_q};
    d_mag = d[32] ? (33'd0 - d) : d;
    p_mag = p_r[31] ? (32'd0 - p_r) : p_r;
    tv    = {2'b00, prod_r[63:16]};
    sv    = pneg_r ? (50'd0 - tv) : tv;
    sum   = sv + {{18{c_r[31]}}, c_r};
    h_ovf = !((&sum[49:31]) || !(|sum[49:31]));
    if (h_ovf) begin
      hval = sum[49] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      hval = sum[31:0];
    end
  end

  // Advance the working registers on command
  always_ff @(posedge clk) begin
    if (ctrl.cap_eval) xev_r <= in_x_value;
    if (ctrl.cap_a) begin
      aw_r <= w_q;
      ax_r <= x_q;
    end
    if (ctrl.div_init) begin
      qneg_r <= num[32] ^ den[32];
      dvd_r  <= {num_mag, 16'd0};
      dvs_r  <= den_mag;
      rem_r  <= '0;
    end else if (ctrl.div_step) begin
      if (!trial[33]) begin
        rem_r <= trial;
        dvd_r <= {dvd_r[47:0], 1'b1};
      end else begin
        rem_r <= {rem_r[32:0], dvd_r[48]};
        dvd_r <= {dvd_r[47:0], 1'b0};
      end
    end
    if (ctrl.p_load) begin
      p_r <= w_q;
    end else if (ctrl.horner_add) begin
      p_r <= hval;
    end
    if (ctrl.mul) begin
      prod_r <= 64'(p_mag) * 64'(d_mag[31:0]);
      pneg_r <= p_r[31] ^ d[32];
      c_r    <= w_q;
    end
    if (ctrl.out_load) begin
      out_poly_r <= ctrl.out_zero ? 32'd0 : p_r;
    end
  end

  assign stat.den_zero  = (ax_r == x_q);
  assign stat.q_sat     = qneg_r ? q_neg_ovf : q_pos_ovf;
  assign stat.h_sat     = h_ovf;
  assign out_poly_value = out_poly_r;

endmodule

`default_nettype wire

// ===== rtl/core/ndd_ctrl.sv =====
// Controller: handshakes, point count, and the sequencer for copy,
// divided differences and Horner evaluation. Depends on ndd_pkg.
`default_nettype none

module ndd_ctrl #(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_opcode,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_status,
  output ndd_pkg::ctrl_t                     ctrl,
  output logic [$clog2(MAX_POINTS)-1:0]      rd_addr,
  output logic [$clog2(MAX_POINTS)-1:0]      x_addr,
  output logic [$clog2(MAX_POINTS)-1:0]      wr_addr,
  input  wire ndd_pkg::stat_t                stat
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_C_RD, S_C_WR, S_D_RD0, S_D_RD1, S_D_SET, S_D_DIV, S_D_WR,
    S_H_INIT, S_H_LDP, S_H_RD, S_H_MUL, S_H_ADD, S_FIN
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    drop_r, drop_nxt;
  logic [IW-1:0]           i_r, i_nxt, j_r, j_nxt;
  logic [ndd_pkg::DIV_KW-1:0] k_r, k_nxt;
  logic                    sat_r, sat_nxt;
  logic [2:0]              res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              out_status_r, out_status_nxt;
  logic [CW-1:0]           cnt_m1;
  logic [IW-1:0]           n1;

  assign cnt_m1 = cnt_r - CW'(1);
  assign n1     = cnt_m1[IW-1:0];

  // Next-state, counters and datapath commands
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    drop_nxt       = drop_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    sat_nxt        = sat_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    ctrl           = '0;
    rd_addr        = i_r;
    x_addr         = i_r;
    wr_addr        = i_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            ndd_pkg::OP_LOAD: begin
              if (cnt_r != CW'(MAX_POINTS)) begin
                ctrl.ld_node = 1'b1;
                wr_addr      = cnt_r[IW-1:0];
                cnt_nxt      = cnt_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            ndd_pkg::OP_EVAL: begin
              ctrl.cap_eval = 1'b1;
              sat_nxt       = 1'b0;
              i_nxt         = '0;
              if (cnt_r == '0) begin
                res_nxt   = ndd_pkg::ST_NONE;
                state_nxt = S_FIN;
              end else begin
                res_nxt   = ndd_pkg::ST_OK;
                state_nxt = S_C_RD;
              end
            end
            ndd_pkg::OP_CLEAR: begin
              cnt_nxt  = '0;
              drop_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      // Copy ordinates into the work store
      S_C_RD: state_nxt = S_C_WR;
      S_C_WR: begin
        ctrl.w_wr_y = 1'b1;
        if (i_r == n1) begin
          if (cnt_r == CW'(1)) begin
            state_nxt = S_H_INIT;
          end else begin
            j_nxt     = IW'(1);
            i_nxt     = n1;
            state_nxt = S_D_RD0;
          end
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_C_RD;
        end
      end
      // Divided differences, in place from the top entry down
      S_D_RD0: state_nxt = S_D_RD1;
      S_D_RD1: begin
        rd_addr    = i_r - IW'(1);
        x_addr     = i_r - j_r;
        ctrl.cap_a = 1'b1;
        state_nxt  = S_D_SET;
      end
      S_D_SET: begin
        if (stat.den_zero) begin
          res_nxt   = ndd_pkg::ST_DUP;
          state_nxt = S_FIN;
        end else begin
          ctrl.div_init = 1'b1;
          k_nxt         = '0;
          state_nxt     = S_D_DIV;
        end
      end
      S_D_DIV: begin
        ctrl.div_step = 1'b1;
        k_nxt         = k_r + ndd_pkg::DIV_KW'(1);
        if (k_r == ndd_pkg::DIV_KW'(ndd_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_D_WR;
        end
      end
      S_D_WR: begin
        ctrl.w_wr_q = 1'b1;
        sat_nxt     = sat_r || stat.q_sat;
        state_nxt   = S_D_RD0;
        if (i_r == j_r) begin
          if (j_r == n1) begin
            state_nxt = S_H_INIT;
          end else begin
            j_nxt = j_r + IW'(1);
            i_nxt = n1;
          end
        end else begin
          i_nxt = i_r - IW'(1);
        end
      end
      // Horner evaluation from the top coefficient
      S_H_INIT: begin
        rd_addr   = n1;
        i_nxt     = n1;
        state_nxt = S_H_LDP;
      end
      S_H_LDP: begin
        ctrl.p_load = 1'b1;
        state_nxt   = (i_r == '0) ? S_FIN : S_H_RD;
      end
      S_H_RD: begin
        rd_addr   = i_r - IW'(1);
        x_addr    = i_r - IW'(1);
        state_nxt = S_H_MUL;
      end
      S_H_MUL: begin
        ctrl.mul  = 1'b1;
        state_nxt = S_H_ADD;
      end
      S_H_ADD: begin
        ctrl.horner_add = 1'b1;
        sat_nxt         = sat_r || stat.h_sat;
        i_nxt           = i_r - IW'(1);
        state_nxt       = (i_r == IW'(1)) ? S_FIN : S_H_RD;
      end
      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          ctrl.out_load = 1'b1;
          ctrl.out_zero = (res_r != ndd_pkg::ST_OK);
          out_valid_nxt = 1'b1;
          if (res_r != ndd_pkg::ST_OK) begin
            out_status_nxt = res_r;
          end else if (sat_r) begin
            out_status_nxt = ndd_pkg::ST_SAT;
          end else if (drop_r) begin
            out_status_nxt = ndd_pkg::ST_DROP;
          end else begin
            out_status_nxt = ndd_pkg::ST_OK;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    sat_r        <= sat_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/newton_divided_difference_interp_top.sv =====
// Top level of the Newton divided-difference interpolator.
// Instantiates ndd_ctrl and ndd_datapath; depends on ndd_pkg.
//
// Load items store one (x, y) node per transfer; loads past MAX_POINTS are
// dropped and flagged. An evaluate item with n stored points first copies the
// ordinates, then forms (n-1)n/2 divided differences on the one-bit-per-cycle
// 49-step restoring divider, then runs the Horner steps on one 32x32
// multiplier and loads the output register.
// The output register lets new items be taken while a result waits.
`default_nettype none

module newton_divided_difference_interp_top #(
  parameter int MAX_POINTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_x_value,
  input  wire logic [31:0] in_y_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_poly_value,
  output logic [2:0]       out_status
);

  localparam int IW = $clog2(MAX_POINTS);

  ndd_pkg::ctrl_t ctrl;
  ndd_pkg::stat_t stat;
  logic [IW-1:0]  rd_addr, x_addr, wr_addr;

  ndd_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .ctrl       (ctrl),
    .rd_addr    (rd_addr),
    .x_addr     (x_addr),
    .wr_addr    (wr_addr),
    .stat       (stat)
  );

  ndd_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk            (clk),
    .in_x_value     (in_x_value),
    .in_y_value     (in_y_value),
    .ctrl           (ctrl),
    .rd_addr        (rd_addr),
    .x_addr         (x_addr),
    .wr_addr        (wr_addr),
    .stat           (stat),
    .out_poly_value (out_poly_value)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ndd_checker.sv =====
// Port-level checker for the interpolator, bound to the top level.
// Depends on ndd_pkg.
`default_nettype none

module ndd_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_poly_value,
  input wire logic [2:0]  out_status
);

  // Stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_poly_value) && $stable(out_status))
    else $error("stalled result changed");

  // Error results carry a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ndd_pkg::ST_NONE || out_status == ndd_pkg::ST_DUP)
      |-> out_poly_value == 32'd0)
    else $error("error result with nonzero value");

  // An evaluate transfer blocks input on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == ndd_pkg::OP_EVAL |=> !in_ready)
    else $error("input taken during evaluation");

  // Reset empties the result register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind newton_divided_difference_interp_top ndd_port_checker u_ndd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_opcode      (in_opcode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_poly_value (out_poly_value),
  .out_status     (out_status)
);

`default_nettype wire

// ===== verif/ndd_checker.sv =====
// Checker for the Newton divided-difference interpolator: watches both channels,
// predicts each evaluate result and compares it. Depends on ndd_pkg.
module ndd_checker #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_x_value,
  input  logic [31:0] in_y_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_poly_value,
  input  logic [2:0]  out_status,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] poly;
    logic [2:0]  status;
  } interp_result_t;

  interp_result_t    expected_results[$];
  logic signed [31:0] node_x[MAX_POINTS];
  logic signed [31:0] node_y[MAX_POINTS];
  logic signed [31:0] coef[MAX_POINTS];
  int                 n_points;
  bit                 dropped;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic signed [31:0] clamp32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Q16.16 product, magnitude truncated toward zero
  function automatic longint fix_mul(input longint a, input longint b);
    longint unsigned ma, mb, prod;
    longint r;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    prod = (ma * mb) >> 16;
    r = longint'(prod);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic interp_result_t interpolate(input logic signed [31:0] xe);
    interp_result_t res;
    bit sat;
    longint num, den, p, d;
    sat = 0;
    res.poly = '0;
    if (n_points == 0) begin
      res.status = ndd_pkg::ST_NONE;
      return res;
    end
    for (int i = 0; i < n_points; i++) coef[i] = node_y[i];
    // build divided differences in place, highest index first
    for (int j = 1; j < n_points; j++) begin
      for (int i = n_points - 1; i >= j; i--) begin
        num = longint'(coef[i]) - longint'(coef[i-1]);
        den = longint'(node_x[i]) - longint'(node_x[i-j]);
        if (den == 0) begin
          res.status = ndd_pkg::ST_DUP;
          return res;
        end
        coef[i] = clamp32((num * 65536) / den, sat);
      end
    end
    // Horner over the node products
    p = coef[n_points-1];
    for (int i = n_points - 1; i > 0; i--) begin
      d = longint'(xe) - longint'(node_x[i-1]);
      p = clamp32(fix_mul(p, d) + longint'(coef[i-1]), sat);
    end
    res.poly = p[31:0];
    res.status = sat ? ndd_pkg::ST_SAT : (dropped ? ndd_pkg::ST_DROP : ndd_pkg::ST_OK);
    return res;
  endfunction

  always @(posedge clk) begin
    interp_result_t want;
    if (!rst_n) begin
      n_points = 0;
      dropped = 0;
      fail_count = 0;
      expected_results.delete();
      pending_count = 0;
    end else begin
      // predict on each input transfer
      if (in_valid && in_ready) begin
        case (in_opcode)
          ndd_pkg::OP_LOAD: begin
            if (n_points < MAX_POINTS) begin
              node_x[n_points] = in_x_value;
              node_y[n_points] = in_y_value;
              n_points = n_points + 1;
            end else begin
              dropped = 1;
            end
          end
          ndd_pkg::OP_EVAL: expected_results.push_back(interpolate(in_x_value));
          ndd_pkg::OP_CLEAR: begin
            n_points = 0;
            dropped = 0;
          end
          default: ;
        endcase
      end
      // compare each result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_poly_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_poly_value !== want.poly)
            report_mismatch("poly_value", out_poly_value, want.poly);
          if (out_status !== want.status)
            report_mismatch("status", {29'd0, out_status}, {29'd0, want.status});
        end
      end
      pending_count = expected_results.size();
    end
  end
endmodule

// ===== verif/newton_divided_difference_interp_top_tb.sv =====
// Testbench top for the Newton divided-difference interpolator: makes stimulus,
// idles both channels and gives the verdict. Depends on ndd_pkg and ndd_checker.
module newton_divided_difference_interp_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = 16;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_opcode = ndd_pkg::OP_LOAD;
  logic [31:0] in_x_value = '0;
  logic [31:0] in_y_value = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_poly_value;
  logic [2:0]  out_status;
  int          fail_count;
  int          pending_count;
  int          items_sent = 0;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          stim_done = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  newton_divided_difference_interp_top #(.MAX_POINTS(MAX_POINTS)) DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_x_value, .in_y_value,
    .out_valid, .out_ready, .out_poly_value, .out_status
  );

  ndd_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_x_value, .in_y_value,
    .out_valid, .out_ready, .out_poly_value, .out_status,
    .fail_count, .pending_count
  );

  // cycle through idling phases as items go out
  always_comb begin
    case ((items_sent / 50) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
    if (stim_done) recv_stall_pct = 0;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transfer, with optional idle cycles in front
  task automatic send(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_x_value <= x;
    in_y_value <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(20)) - 10) <<< 16;
    endcase
  endfunction

  initial begin
    int k;
    logic [31:0] xn;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: empty set, extremes, duplicate, ignored opcode, full store
    send(ndd_pkg::OP_EVAL, 32'h0001_0000, '0);
    send(ndd_pkg::OP_LOAD, 32'h7fffffff, 32'h80000000);
    send(ndd_pkg::OP_EVAL, 32'h0, '0);
    send(ndd_pkg::OP_LOAD, 32'h80000000, 32'h7fffffff);
    send(ndd_pkg::OP_EVAL, 32'h7fffffff, '0);
    send(ndd_pkg::OP_EVAL, 32'h80000000, '0);
    send(ndd_pkg::OP_LOAD, 32'h7fffffff, 32'h0);
    send(ndd_pkg::OP_EVAL, 32'h0, '0);
    send(2'd3, 32'hffffffff, 32'hffffffff);
    send(ndd_pkg::OP_CLEAR, 32'hffffffff, 32'hffffffff);
    send(ndd_pkg::OP_EVAL, 32'h0, '0);
    for (int i = 0; i < MAX_POINTS + 2; i++)
      send(ndd_pkg::OP_LOAD, 32'(i) << 16, 32'(i * i) << 14);
    send(ndd_pkg::OP_EVAL, 32'h0002_8000, '0);
    send(ndd_pkg::OP_CLEAR, '0, '0);

    // random sequences: mostly clear, load a handful, evaluate
    while (items_sent < 520) begin
      if ($urandom_range(9) != 0) send(ndd_pkg::OP_CLEAR, $urandom, $urandom);
      case ($urandom_range(99)) inside
        [0:69]:  k = $urandom_range(4, 1);
        [70:89]: k = $urandom_range(8, 5);
        [90:96]: k = $urandom_range(16, 9);
        default: k = $urandom_range(19, 16);
      endcase
      xn = $urandom_range(1) ? $urandom : (32'($urandom_range(8)) << 16);
      for (int i = 0; i < k; i++) begin
        case ($urandom_range(9))
          0: ;  // repeat the previous abscissa
          1, 2: xn = $urandom;
          default: xn = xn + (32'($urandom_range(3, 1)) << 16) + 32'($urandom_range(255));
        endcase
        send(ndd_pkg::OP_LOAD, xn, rand_value());
      end
      repeat ($urandom_range(3, 1)) send(ndd_pkg::OP_EVAL, rand_value(), $urandom);
      if ($urandom_range(19) == 0) send(2'($urandom_range(3)), $urandom, $urandom);
    end
    in_valid <= 0;
    stim_done = 1;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== newton_divided_difference_interp_top.f =====
rtl/core/ndd_pkg.sv
rtl/core/ndd_datapath.sv
rtl/core/ndd_ctrl.sv
rtl/core/newton_divided_difference_interp_top.sv
rtl/core/ndd_checker.sv
verif/ndd_checker.sv
verif/newton_divided_difference_interp_top_tb.sv
